>>> src/cfq_pkg.sv
// Shared types and constants for the circular FIFO queue.
`default_nettype none
package cfq_pkg;

   localparam int DATA_W = 32;
   localparam int OCC_W  = 6;
   localparam int CAP_W  = 6;
   localparam int CAP_LIMIT = 32;

   typedef enum logic [2:0] {
      OP_ENQ  = 3'd0,
      OP_DEQ  = 3'd1,
      OP_SHOW = 3'd2,
      OP_PEEK = 3'd3,
      OP_CNT  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_OVERFLOW = 2'd1,
      STS_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  data;
      logic [OCC_W-1:0]          occupancy;
      logic                      last;
   } rsp_type;

endpackage
`default_nettype wire

>>> src/cfq_if.sv
// Request and response channel interfaces of the circular FIFO queue.
`default_nettype none
interface cfq_req_if;
   logic                               valid;
   logic                               ready;
   logic [2:0]                         opcode;
   logic signed [cfq_pkg::DATA_W-1:0]  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

interface cfq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic signed [cfq_pkg::DATA_W-1:0]  data;
   logic [cfq_pkg::OCC_W-1:0]          occupancy;
   logic                               last;

   modport source (output valid, output status, output data, output occupancy,
                   output last, input ready);
   modport sink (input valid, input status, input data, input occupancy,
                 input last, output ready);
endinterface
`default_nettype wire

>>> src/cfq_ram.sv
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module cfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/cfq_front.sv
// Front end: accepts request transfers, drops unknown opcodes, queues commands.
`default_nettype none
module cfq_front (
   input  wire logic        clock,
   input  wire logic        reset,
   cfq_req_if.sink          req,
   output logic             cmd_valid,
   output cfq_pkg::cmd_type cmd,
   input  wire logic        cmd_ready
);

   cfq_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             known_op;
   logic             push;
   logic             pop;

   assign known_op  = (req.opcode <= cfq_pkg::OP_CNT);
   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready && known_op;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: cfq_pkg::op_type'(req.opcode), value: req.value};
      end
   end

endmodule
`default_nettype wire

>>> src/cfq_back.sv
// Back end: executes queued commands against the ring storage and drives responses.
`default_nettype none
module cfq_back #(
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [cfq_pkg::CAP_W-1:0]  csr_wr_data,
   input  wire logic                       cmd_valid,
   input  cfq_pkg::cmd_type                cmd,
   output logic                            cmd_ready,
   cfq_rsp_if.source                       rsp
);

   localparam int AW      = $clog2(DEPTH);
   localparam int XW      = (AW > cfq_pkg::CAP_W) ? AW + 1 : cfq_pkg::CAP_W + 1;
   localparam int CAP_MAX = (DEPTH < cfq_pkg::CAP_LIMIT) ? DEPTH : cfq_pkg::CAP_LIMIT;

   typedef enum logic [1:0] {
      BS_IDLE = 2'b01,
      BS_READ = 2'b10
   } bstate_type;

   bstate_type                   state_ff, state_in;
   cfq_pkg::op_type              op_ff, op_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [AW-1:0]                tail_ff, tail_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [cfq_pkg::OCC_W-1:0]    count_ff, count_in;
   logic [cfq_pkg::OCC_W-1:0]    remain_ff, remain_in;
   logic [cfq_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cfq_pkg::rsp_type             rsp_ff, rsp_in;
   logic                         out_free;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [cfq_pkg::DATA_W-1:0]   rd_data;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                             input logic [cfq_pkg::CAP_W-1:0] cap);
      logic [XW-1:0] nxt;
      nxt = XW'(idx) + XW'(1);
      return (nxt >= XW'(cap)) ? '0 : AW'(nxt);
   endfunction

   function automatic cfq_pkg::rsp_type make_rsp(input cfq_pkg::status_type status,
                                                 input logic [cfq_pkg::DATA_W-1:0] data,
                                                 input logic [cfq_pkg::OCC_W-1:0] occ,
                                                 input logic last);
      cfq_pkg::rsp_type r;
      r.status    = status;
      r.data      = data;
      r.occupancy = occ;
      r.last      = last;
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      cmd_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      case (state_ff)
         BS_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               case (cmd.op)
                  cfq_pkg::OP_ENQ: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= cap_ff) begin
                        rsp_in = make_rsp(cfq_pkg::STS_OVERFLOW, '0, count_ff, 1'b1);
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = advance(tail_ff, cap_ff);
                        count_in = count_ff + 6'd1;
                        rsp_in   = make_rsp(cfq_pkg::STS_OK, cmd.value, count_in, 1'b1);
                     end
                  end
                  cfq_pkg::OP_DEQ, cfq_pkg::OP_PEEK, cfq_pkg::OP_SHOW: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(cfq_pkg::STS_EMPTY, '0, count_ff, 1'b1);
                     end else begin
                        rd_en     = 1'b1;
                        op_in     = cmd.op;
                        idx_in    = advance(head_ff, cap_ff);
                        remain_in = count_ff;
                        state_in  = BS_READ;
                     end
                  end
                  cfq_pkg::OP_CNT: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = make_rsp(cfq_pkg::STS_OK, '0, count_ff, 1'b1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         BS_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               case (op_ff)
                  cfq_pkg::OP_DEQ: begin
                     head_in  = idx_ff;
                     count_in = count_ff - 6'd1;
                     rsp_in   = make_rsp(cfq_pkg::STS_OK, rd_data, count_in, 1'b1);
                     state_in = BS_IDLE;
                  end
                  cfq_pkg::OP_SHOW: begin
                     rsp_in = make_rsp(cfq_pkg::STS_OK, rd_data, count_ff,
                                       remain_ff == 6'd1);
                     if (remain_ff == 6'd1) begin
                        state_in = BS_IDLE;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = idx_ff;
                        idx_in    = advance(idx_ff, cap_ff);
                        remain_in = remain_ff - 6'd1;
                     end
                  end
                  default: begin
                     rsp_in   = make_rsp(cfq_pkg::STS_OK, rd_data, count_ff, 1'b1);
                     state_in = BS_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase

      // A capacity write also empties the queue.
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            cap_in = 6'd1;
         end else if (csr_wr_data > 6'(CAP_MAX)) begin
            cap_in = 6'(CAP_MAX);
         end else begin
            cap_in = csr_wr_data;
         end
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= 6'(CAP_MAX);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      remain_ff <= remain_in;
      rsp_ff    <= rsp_in;
   end

   cfq_ram #(
      .WIDTH (cfq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_ff.status;
   assign rsp.data      = rsp_ff.data;
   assign rsp.occupancy = rsp_ff.occupancy;
   assign rsp.last      = rsp_ff.last;

endmodule
`default_nettype wire

>>> src/circular_fifo_queue.sv
// A request is held in the front-end command buffer, then run by the back end, which registers its response.
// Enqueue, count and empty-queue cases are answered directly from the idle state of the execution unit.
// Dequeue and peek pass through the read state, waiting on the registered read of the slot RAM.
// Show-all returns one response per stored word, from oldest to newest.
// Reset empties the queue and sets the capacity to its maximum; the RAM is not cleared.
`default_nettype none
module circular_fifo_queue #(
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   cfq_req_if.sink                         req_if,
   cfq_rsp_if.source                       rsp_if,
   input  wire logic                       csr_wr_en,
   input  wire logic [cfq_pkg::CAP_W-1:0]  csr_wr_data
);

   logic             cmd_valid;
   logic             cmd_ready;
   cfq_pkg::cmd_type cmd;

   cfq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   cfq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .rsp         (rsp_if)
   );

endmodule
`default_nettype wire

>>> sim/circular_fifo_queue_tb.sv
// Self-checking testbench for the circular FIFO queue with a built-in queue predictor.
`timescale 1ns / 1ps
module circular_fifo_queue_tb;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_wr_en;
   logic [cfq_pkg::CAP_W-1:0]    csr_wr_data;

   cfq_req_if req_bus ();
   cfq_rsp_if rsp_bus ();

   circular_fifo_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cfq_pkg::cmd_type     cmd_backlog [$];
   cfq_pkg::rsp_type     awaited_rsps [$];
   cfq_pkg::cmd_type     on_bus;
   int                   send_idle_pct;
   int                   recv_stall_pct;
   int                   error_count = 0;
   int                   cycle_count = 0;

   logic signed [cfq_pkg::DATA_W-1:0] ring [cfq_pkg::CAP_LIMIT];
   logic [4:0]                        head_ptr = '0;
   logic [4:0]                        tail_ptr = '0;
   logic [cfq_pkg::OCC_W-1:0]         fill = '0;
   logic [cfq_pkg::CAP_W-1:0]         cap_reg = 6'd32;

   function automatic int ring_limit();
      int c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > cfq_pkg::CAP_LIMIT) c = cfq_pkg::CAP_LIMIT;
      return c;
   endfunction

   function automatic logic [4:0] ring_next(input logic [4:0] idx);
      return (int'(idx) + 1 >= ring_limit()) ? 5'd0 : idx + 5'd1;
   endfunction

   function automatic void fifo_predict(input cfq_pkg::cmd_type cmd);
      cfq_pkg::rsp_type r;
      logic [4:0]       idx;
      int               k;
      r.status    = cfq_pkg::STS_OK;
      r.data      = '0;
      r.occupancy = '0;
      r.last      = 1'b1;
      case (cmd.op)
         cfq_pkg::OP_ENQ: begin
            if (fill >= ring_limit()) begin
               r.status = cfq_pkg::STS_OVERFLOW;
            end else begin
               ring[tail_ptr] = cmd.value;
               tail_ptr = ring_next(tail_ptr);
               fill++;
               r.data = cmd.value;
            end
            r.occupancy = fill;
            awaited_rsps.push_back(r);
         end
         cfq_pkg::OP_DEQ: begin
            if (fill == 0) begin
               r.status = cfq_pkg::STS_EMPTY;
            end else begin
               r.data = ring[head_ptr];
               head_ptr = ring_next(head_ptr);
               fill--;
            end
            r.occupancy = fill;
            awaited_rsps.push_back(r);
         end
         cfq_pkg::OP_SHOW: begin
            r.occupancy = fill;
            if (fill == 0) begin
               r.status = cfq_pkg::STS_EMPTY;
               awaited_rsps.push_back(r);
            end else begin
               idx = head_ptr;
               for (k = 0; k < fill; k++) begin
                  r.data = ring[idx];
                  r.last = (k + 1 == fill);
                  awaited_rsps.push_back(r);
                  idx = ring_next(idx);
               end
            end
         end
         cfq_pkg::OP_PEEK: begin
            if (fill == 0) r.status = cfq_pkg::STS_EMPTY;
            else r.data = ring[head_ptr];
            r.occupancy = fill;
            awaited_rsps.push_back(r);
         end
         cfq_pkg::OP_CNT: begin
            r.occupancy = fill;
            awaited_rsps.push_back(r);
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : cmd_driver
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_reg  = csr_wr_data;
            head_ptr = '0;
            tail_ptr = '0;
            fill     = '0;
         end
         if (req_bus.valid && req_bus.ready) fifo_predict(on_bus);
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = cmd_backlog.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.opcode <= on_bus.op;
               req_bus.value  <= on_bus.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      cfq_pkg::rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("unexpected result transfer: status %0d data %0d occupancy %0d last %0d",
                      rsp_bus.status, rsp_bus.data, rsp_bus.occupancy, rsp_bus.last);
               error_count++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.data !== want.data) begin
                  $error("data: expected %0d, got %0d", want.data, rsp_bus.data);
                  error_count++;
               end
               if (rsp_bus.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         rsp_bus.occupancy);
                  error_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
                  error_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic signed [cfq_pkg::DATA_W-1:0] random_word();
      case ($urandom_range(15))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_cmd(input cfq_pkg::op_type op,
                            input logic signed [cfq_pkg::DATA_W-1:0] word);
      cfq_pkg::cmd_type c;
      c.op    = op;
      c.value = word;
      cmd_backlog.push_back(c);
   endtask

   task automatic queue_random_cmds(input int count, input int enq_pct);
      cfq_pkg::op_type op;
      int              k;
      for (k = 0; k < count; k++) begin
         if ($urandom_range(99) < enq_pct) begin
            op = cfq_pkg::OP_ENQ;
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3: op = cfq_pkg::OP_DEQ;
               4, 5:       op = cfq_pkg::OP_PEEK;
               6, 7:       op = cfq_pkg::OP_CNT;
               8:          op = cfq_pkg::OP_SHOW;
               default:    op = cfq_pkg::op_type'($urandom_range(7, 5));
            endcase
         end
         queue_cmd(op, random_word());
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (cmd_backlog.size() != 0 || awaited_rsps.size() != 0 || req_bus.valid)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [cfq_pkg::CAP_W-1:0] cap);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
         default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
   endtask

   logic [cfq_pkg::CAP_W-1:0] phase_caps [8] = '{6'd0, 6'd63, 6'd7, 6'd1, 6'd32, 6'd3, 6'd20,
                                                 6'd5};

   initial begin
      int phase;
      int lim;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      set_idling(0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_cmd(cfq_pkg::OP_DEQ, 32'sd5);
      queue_cmd(cfq_pkg::OP_PEEK, 32'sd6);
      queue_cmd(cfq_pkg::OP_CNT, 32'sd7);
      queue_cmd(cfq_pkg::OP_SHOW, 32'sd8);
      queue_cmd(cfq_pkg::OP_ENQ, 32'sh7fff_ffff);
      queue_cmd(cfq_pkg::OP_ENQ, 32'sh8000_0000);
      queue_cmd(cfq_pkg::OP_ENQ, 32'sd0);
      queue_cmd(cfq_pkg::OP_ENQ, -32'sd1);
      queue_cmd(cfq_pkg::OP_PEEK, 32'sd0);
      queue_cmd(cfq_pkg::OP_CNT, 32'sd0);
      queue_cmd(cfq_pkg::OP_SHOW, 32'sd0);
      queue_cmd(cfq_pkg::op_type'(3'd5), 32'sd1);
      queue_cmd(cfq_pkg::op_type'(3'd6), 32'sd2);
      queue_cmd(cfq_pkg::op_type'(3'd7), 32'sd3);
      queue_cmd(cfq_pkg::OP_DEQ, 32'sd0);
      queue_cmd(cfq_pkg::OP_DEQ, 32'sd0);
      write_capacity(6'd2);
      queue_cmd(cfq_pkg::OP_ENQ, 32'sd11);
      queue_cmd(cfq_pkg::OP_ENQ, 32'sd22);
      queue_cmd(cfq_pkg::OP_ENQ, 32'sd33);
      queue_cmd(cfq_pkg::OP_SHOW, 32'sd0);
      queue_cmd(cfq_pkg::OP_DEQ, 32'sd0);
      queue_cmd(cfq_pkg::OP_ENQ, 32'sd44);
      queue_cmd(cfq_pkg::OP_SHOW, 32'sd0);
      queue_cmd(cfq_pkg::OP_DEQ, 32'sd0);
      queue_cmd(cfq_pkg::OP_DEQ, 32'sd0);
      queue_cmd(cfq_pkg::OP_DEQ, 32'sd0);

      for (phase = 0; phase < 8; phase++) begin
         write_capacity(phase_caps[phase]);
         set_idling(phase % 4);
         lim = (phase_caps[phase] < 1) ? 1 :
               (phase_caps[phase] > cfq_pkg::CAP_LIMIT) ? cfq_pkg::CAP_LIMIT :
               int'(phase_caps[phase]);
         queue_random_cmds(lim + 2, 90);
         wait_idle();
         queue_random_cmds(lim + 2, 10);
      end

      wait_idle();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
